// ===== src/mlfs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlfs_pkg: shared types and constants of the LED frame serializer
// Request codes, queue entry layout and the fixed field widths.
// ----------------------------------------------------------------------------
package mlfs_pkg;

    localparam int DEF_ARM_LEDS  = 16;
    localparam int DEF_ARM_COUNT = 4;

    // Fixed widths of the stream fields.
    localparam int REQ_W    = 2;
    localparam int INDEX_W  = 6;
    localparam int CHAN_W   = 8;
    localparam int COLOUR_W = 3 * CHAN_W;
    localparam int BRIGHT_W = 5;
    localparam int LANE_MAX = 4;

    // Sized for the largest arm length of 256 LEDs.
    localparam int ARM_W   = 2;
    localparam int ADDR_W  = 8;
    localparam int POS_W   = 14;
    localparam int BYTE_W  = POS_W - 3;

    localparam int HEAD_BYTES  = 4;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [CHAN_W-1:0] HEAD_BYTE = 8'h00;
    localparam logic [CHAN_W-1:0] TAIL_BYTE = 8'hFF;
    localparam logic [2:0]        LED_MARK  = 3'b111;
    localparam logic [BRIGHT_W-1:0] BRIGHT_RESET = 5'd31;

    typedef enum logic [REQ_W-1:0] {
        REQ_WRITE = 2'd0,
        REQ_FILL  = 2'd1,
        REQ_START = 2'd2,
        REQ_TICK  = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_FILL  = 2'd1,
        OP_TICK  = 2'd2
    } op_t;

    typedef struct packed {
        op_t                 op;
        logic [ARM_W-1:0]    arm;
        logic [ADDR_W-1:0]   addr;
        logic [COLOUR_W-1:0] colour;   // {red, green, blue}
        logic [POS_W-1:0]    pos;
        logic                last;
    } q_entry_t;

endpackage

// ===== src/multi_lane_led_frame_serializer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_lane_led_frame_serializer: parallel-arm LED strip frame driver
// Stores a colour per LED and shifts out LED frames on up to four arms.
// ----------------------------------------------------------------------------
// With an empty queue, an accepted tick beat is queued, then popped into the
// registered output beat that raises m_tvalid. Input beats are taken one per
// cycle while the front-to-back queue has room; a fill request occupies the
// store sweep over every LED address. After reset a clearing pass zeroes the
// pixel store; s_tready stays low until it finishes. Brightness resets to 31.
// ----------------------------------------------------------------------------
module multi_lane_led_frame_serializer
    import mlfs_pkg::*;
#(
    parameter int ARM_LEDS  = DEF_ARM_LEDS,
    parameter int ARM_COUNT = DEF_ARM_COUNT
) (
    input  logic                aclk,
    input  logic                aresetn,

    // Request stream.
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [31:0]         s_tdata,   // led_index[5:0], red[13:6],
                                           // green[21:14], blue[29:22], zero
    input  logic [REQ_W-1:0]    s_tuser,   // req_type[1:0]

    // Serial bit stream, one beat per tick during a send.
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,   // lane_bits[3:0], zero[7:4]
    output logic                m_tlast,   // last_bit

    // Brightness register write channel.
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [BRIGHT_W-1:0] cfg_data
);

    logic [BRIGHT_W-1:0] bright_reg, bright_next;
    logic                accept;
    logic                push;
    q_entry_t            push_entry;
    q_entry_t            head;
    logic                q_empty;
    logic                q_full;
    logic                pop;
    logic                init_done;
    logic [LANE_MAX-1:0] out_lanes;
    logic [COLOUR_W-1:0] colour;

    // Configuration is accepted in any cycle.
    assign cfg_ready = 1'b1;

    always_comb begin
        bright_next = bright_reg;
        if (cfg_valid && cfg_ready) begin
            bright_next = cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bright_reg <= BRIGHT_RESET;
        end else begin
            bright_reg <= bright_next;
        end
    end

    // The store is packed red, green, blue from high to low byte.
    assign colour = {s_tdata[13:6], s_tdata[21:14], s_tdata[29:22]};

    // Input beats wait for queue room and for the clearing pass to end.
    assign s_tready = init_done && !q_full;
    assign accept   = s_tvalid && s_tready;

    mlfs_front #(
        .ARM_LEDS  (ARM_LEDS),
        .ARM_COUNT (ARM_COUNT)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .req_type   (s_tuser),
        .led_index  (s_tdata[INDEX_W-1:0]),
        .colour     (colour),
        .push       (push),
        .push_entry (push_entry)
    );

    mlfs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .empty      (q_empty),
        .full       (q_full)
    );

    mlfs_back #(
        .ARM_LEDS  (ARM_LEDS),
        .ARM_COUNT (ARM_COUNT)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .brightness (bright_reg),
        .head       (head),
        .q_empty    (q_empty),
        .pop        (pop),
        .init_done  (init_done),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_lanes  (out_lanes),
        .out_last   (m_tlast)
    );

    assign m_tdata = {4'b0000, out_lanes};

endmodule

// ===== src/mlfs_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlfs_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mlfs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/mlfs_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlfs_queue: short FIFO between front and back
// Register-based queue of operation entries; DEPTH is a power of two.
// ----------------------------------------------------------------------------
module mlfs_queue
    import mlfs_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  q_entry_t push_entry,
    input  logic     pop,
    output q_entry_t head,
    output logic     empty,
    output logic     full
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    q_entry_t         slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== src/mlfs_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlfs_front: request classifier and frame sequencer
// Drops writes, fills and starts during a send and ticks outside one, maps LED
// numbers to arm and position, and tags each tick with its frame bit position.
// ----------------------------------------------------------------------------
module mlfs_front
    import mlfs_pkg::*;
#(
    parameter int ARM_LEDS  = DEF_ARM_LEDS,
    parameter int ARM_COUNT = DEF_ARM_COUNT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                accept,
    input  logic [REQ_W-1:0]    req_type,
    input  logic [INDEX_W-1:0]  led_index,
    input  logic [COLOUR_W-1:0] colour,
    output logic                push,
    output q_entry_t            push_entry
);

    localparam int LED_TOTAL  = ARM_LEDS * ARM_COUNT;
    localparam int FRAME_BITS =
        (HEAD_BYTES + 4 * ARM_LEDS + (ARM_LEDS + 15) / 16) * 8;
    localparam int WIDE_W = 11;

    logic             sending_reg, sending_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             last_bit;
    logic [ARM_W-1:0] arm_sel;
    logic [WIDE_W-1:0] arm_base;
    logic [WIDE_W-1:0] arm_pos;
    req_t             req;

    assign req      = req_t'(req_type);
    assign last_bit = (pos_reg == POS_W'(FRAME_BITS - 1));

    // Arm number by comparison against the arm boundaries.
    always_comb begin
        arm_sel = '0;
        for (int k = 1; k < ARM_COUNT; k++) begin
            if (WIDE_W'(led_index) >= WIDE_W'(k * ARM_LEDS)) begin
                arm_sel = ARM_W'(k);
            end
        end
    end

    assign arm_base = WIDE_W'(arm_sel) * WIDE_W'(ARM_LEDS);
    assign arm_pos  = WIDE_W'(led_index) - arm_base;

    always_comb begin
        sending_next      = sending_reg;
        pos_next          = pos_reg;
        push              = 1'b0;
        push_entry.op     = OP_TICK;
        push_entry.arm    = arm_sel;
        push_entry.addr   = arm_pos[ADDR_W-1:0];
        push_entry.colour = colour;
        push_entry.pos    = pos_reg;
        push_entry.last   = last_bit;
        if (accept) begin
            unique case (req)
                REQ_WRITE: begin
                    push_entry.op = OP_WRITE;
                    push = !sending_reg && (WIDE_W'(led_index) < WIDE_W'(LED_TOTAL));
                end
                REQ_FILL: begin
                    push_entry.op = OP_FILL;
                    push          = !sending_reg;
                end
                REQ_START: begin
                    if (!sending_reg) begin
                        sending_next = 1'b1;
                        pos_next     = '0;
                    end
                end
                REQ_TICK: begin
                    if (sending_reg) begin
                        push = 1'b1;
                        if (last_bit) begin
                            sending_next = 1'b0;
                            pos_next     = '0;
                        end else begin
                            pos_next = pos_reg + 1'b1;
                        end
                    end
                end
                default: begin
                    push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sending_reg <= 1'b0;
            pos_reg     <= '0;
        end else begin
            sending_reg <= sending_next;
            pos_reg     <= pos_next;
        end
    end

endmodule

// ===== src/mlfs_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlfs_back: pixel store and bit generator
// Executes queued writes, fills and ticks against one RAM per arm and
// drives the registered output beat.
// ----------------------------------------------------------------------------
module mlfs_back
    import mlfs_pkg::*;
#(
    parameter int ARM_LEDS  = DEF_ARM_LEDS,
    parameter int ARM_COUNT = DEF_ARM_COUNT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [BRIGHT_W-1:0] brightness,
    input  q_entry_t            head,
    input  logic                q_empty,
    output logic                pop,
    output logic                init_done,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [LANE_MAX-1:0] out_lanes,
    output logic                out_last
);

    localparam int LA_W       = (ARM_LEDS > 1) ? $clog2(ARM_LEDS) : 1;
    localparam int BODY_BYTES = 4 * ARM_LEDS;

    typedef enum logic [1:0] {
        ST_SWEEP = 2'b01,
        ST_RUN   = 2'b10
    } back_state_t;

    back_state_t         state_reg, state_next;
    logic [LA_W-1:0]     sweep_addr_reg, sweep_addr_next;
    logic [COLOUR_W-1:0] sweep_colour_reg, sweep_colour_next;
    logic                init_done_reg, init_done_next;
    logic                valid_reg, valid_next;
    logic [LANE_MAX-1:0] lanes_reg, lanes_next;
    logic                last_reg, last_next;

    logic [ARM_COUNT-1:0] ram_we;
    logic [LA_W-1:0]      ram_waddr;
    logic [COLOUR_W-1:0]  ram_wdata;
    logic                 ram_re;
    logic [LA_W-1:0]      ram_raddr;
    logic [COLOUR_W-1:0]  ram_rdata [ARM_COUNT];

    logic [BYTE_W-1:0]    byte_idx;
    logic [BYTE_W-1:0]    rel;
    logic                 in_head;
    logic                 in_body;
    logic [1:0]           slot;
    logic [2:0]           bit_sel;
    logic [LANE_MAX-1:0]  lanes_calc;
    logic                 slot_free;

    assign byte_idx  = head.pos[POS_W-1:3];
    assign rel       = byte_idx - BYTE_W'(HEAD_BYTES);
    assign in_head   = (byte_idx < BYTE_W'(HEAD_BYTES));
    assign in_body   = !in_head && (rel < BYTE_W'(BODY_BYTES));
    assign slot      = rel[1:0];
    assign bit_sel   = ~head.pos[2:0];   // most significant bit first
    assign ram_raddr = rel[LA_W+1:2];
    assign slot_free = !valid_reg || out_ready;

    // One frame byte per arm; colour bytes come from the RAM read issued
    // on the first bit of the LED's header byte.
    always_comb begin
        logic [CHAN_W-1:0] fb;
        lanes_calc = '0;
        for (int k = 0; k < ARM_COUNT; k++) begin
            if (in_head) begin
                fb = HEAD_BYTE;
            end else if (!in_body) begin
                fb = TAIL_BYTE;
            end else begin
                unique case (slot)
                    2'd0:    fb = {LED_MARK, brightness};
                    2'd1:    fb = ram_rdata[k][CHAN_W-1:0];
                    2'd2:    fb = ram_rdata[k][2*CHAN_W-1:CHAN_W];
                    default: fb = ram_rdata[k][3*CHAN_W-1:2*CHAN_W];
                endcase
            end
            lanes_calc[k] = fb[bit_sel];
        end
    end

    always_comb begin
        state_next        = state_reg;
        sweep_addr_next   = sweep_addr_reg;
        sweep_colour_next = sweep_colour_reg;
        init_done_next    = init_done_reg;
        valid_next        = valid_reg;
        lanes_next        = lanes_reg;
        last_next         = last_reg;
        pop               = 1'b0;
        ram_we            = '0;
        ram_waddr         = head.addr[LA_W-1:0];
        ram_wdata         = head.colour;
        ram_re            = 1'b0;

        if (valid_reg && out_ready) begin
            valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_SWEEP: begin
                ram_we    = '1;
                ram_waddr = sweep_addr_reg;
                ram_wdata = sweep_colour_reg;
                if (sweep_addr_reg == LA_W'(ARM_LEDS - 1)) begin
                    state_next      = ST_RUN;
                    init_done_next  = 1'b1;
                    sweep_addr_next = '0;
                end else begin
                    sweep_addr_next = sweep_addr_reg + 1'b1;
                end
            end
            ST_RUN: begin
                if (!q_empty) begin
                    unique case (head.op)
                        OP_WRITE: begin
                            pop = 1'b1;
                            for (int k = 0; k < ARM_COUNT; k++) begin
                                ram_we[k] = (head.arm == ARM_W'(k));
                            end
                        end
                        OP_FILL: begin
                            pop               = 1'b1;
                            sweep_colour_next = head.colour;
                            sweep_addr_next   = '0;
                            state_next        = ST_SWEEP;
                        end
                        OP_TICK: begin
                            if (slot_free) begin
                                pop        = 1'b1;
                                valid_next = 1'b1;
                                lanes_next = lanes_calc;
                                last_next  = head.last;
                                ram_re     = in_body && (slot == 2'd0) &&
                                             (head.pos[2:0] == 3'd0);
                            end
                        end
                        default: begin
                            pop = 1'b1;
                        end
                    endcase
                end
            end
            default: begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_SWEEP;
            sweep_addr_reg   <= '0;
            sweep_colour_reg <= '0;
            init_done_reg    <= 1'b0;
            valid_reg        <= 1'b0;
        end else begin
            state_reg        <= state_next;
            sweep_addr_reg   <= sweep_addr_next;
            sweep_colour_reg <= sweep_colour_next;
            init_done_reg    <= init_done_next;
            valid_reg        <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        lanes_reg <= lanes_next;
        last_reg  <= last_next;
    end

    for (genvar g = 0; g < ARM_COUNT; g++) begin : g_arm
        mlfs_ram #(
            .WIDTH (COLOUR_W),
            .DEPTH (ARM_LEDS)
        ) u_ram (
            .aclk  (aclk),
            .we    (ram_we[g]),
            .waddr (ram_waddr),
            .wdata (ram_wdata),
            .re    (ram_re),
            .raddr (ram_raddr),
            .rdata (ram_rdata[g])
        );
    end

    assign init_done = init_done_reg;
    assign out_valid = valid_reg;
    assign out_lanes = lanes_reg;
    assign out_last  = last_reg;

endmodule
